@@ rtl/scaa_pkg.sv @@
// shared types, codes and sizes of the sparse coordinate-list add accumulator
package scaa_pkg;

  localparam int CAPACITY   = 64;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CFG_ADDR_W = 5;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_ADD    = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_ENTRY    = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_MISMATCH = 2'd2,
    STAT_OVERFLOW = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    REG_FIRST_ROWS     = 3'd0,
    REG_FIRST_COLS     = 3'd1,
    REG_SECOND_ROWS    = 3'd2,
    REG_SECOND_COLS    = 3'd3,
    REG_ZERO_THRESHOLD = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_EMIT   = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        row;
    logic [15:0]        col;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        out_row;
    logic [15:0]        out_col;
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        row;
    logic [15:0]        col;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    logic [15:0] first_rows;
    logic [15:0] first_cols;
    logic [15:0] second_rows;
    logic [15:0] second_cols;
    logic [30:0] zero_threshold;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic  latch;
    logic  clear;
    logic  append;
    logic  scan_start;
    logic  scan;
    logic  update;
    logic  prune;
    logic  emit_final;
    logic  emit_err;
    stat_t err_code;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic             match;
    logic             scan_done;
    logic             mismatch;
    logic             overflow;
    logic [CNT_W-1:0] count;
  } dp_stat_t;

endpackage

@@ rtl/scaa_datapath.sv @@
// entry table memory, scan counter, saturating adder, pruning and result register
module scaa_datapath import scaa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_t      ctl,
  input  in_word_t  in_data,
  input  cfg_t      cfg,
  output dp_stat_t  st,
  output logic      out_valid,
  output out_word_t out_data
);

  entry_t mem [CAPACITY];

  entry_t           in_r;
  entry_t           rdata_r;
  entry_t           pend_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] scan_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             ovf_r;
  logic             chk_vld_r;
  logic             pend_vld_r;
  logic             out_valid_r;
  out_word_t        out_r;

  entry_t           app_src;
  entry_t           wr_data;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  logic             full;
  logic             issue;
  logic             hit;
  logic signed [32:0] sum;
  logic [31:0]      sat_val;
  logic [31:0]      mag;
  logic             keep;
  logic             survivor;
  logic             out_valid_nxt;
  out_word_t        out_nxt;

  always_comb begin
    app_src = ctl.latch ? entry_t'({in_data.row, in_data.col, in_data.value}) : in_r;
    full    = (count_r == CNT_W'(CAPACITY));
    issue   = ctl.scan && (scan_r < count_r);
    hit     = chk_vld_r && (rdata_r.row == in_r.row) && (rdata_r.col == in_r.col);

    // saturating q16.16 add
    sum = {rdata_r.value[31], rdata_r.value} + {in_r.value[31], in_r.value};
    if (sum[32] != sum[31]) begin
      sat_val = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat_val = sum[31:0];
    end

    wr_en   = 1'b0;
    wr_addr = count_r[IDX_W-1:0];
    wr_data = app_src;
    if (ctl.update) begin
      wr_en   = 1'b1;
      wr_addr = chk_idx_r;
      wr_data = {rdata_r.row, rdata_r.col, sat_val};
    end else if (ctl.append && !full) begin
      wr_en = 1'b1;
    end

    // exact magnitude, most negative value maps to 2^31
    mag      = rdata_r.value[31] ? (~rdata_r.value + 32'd1) : rdata_r.value;
    keep     = (mag >= {1'b0, cfg.zero_threshold});
    survivor = ctl.prune && chk_vld_r && keep;

    out_valid_nxt = ctl.emit_err || ctl.emit_final || (survivor && pend_vld_r);
    if (ctl.emit_err) begin
      out_nxt = {16'd0, 16'd0, 32'sd0, ctl.err_code, 1'b1};
    end else if (ctl.emit_final && !pend_vld_r) begin
      out_nxt = {16'd0, 16'd0, 32'sd0, STAT_EMPTY, 1'b1};
    end else begin
      out_nxt = {pend_r.row, pend_r.col, pend_r.value, STAT_ENTRY, ctl.emit_final};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata_r <= mem[scan_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      scan_r      <= '0;
      chk_vld_r   <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.clear) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (ctl.append && !ctl.update) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (ctl.scan_start) begin
        scan_r     <= '0;
        chk_vld_r  <= 1'b0;
        pend_vld_r <= 1'b0;
      end else begin
        if (ctl.scan) begin
          chk_vld_r <= issue;
          if (issue) begin
            scan_r <= scan_r + CNT_W'(1);
          end
        end
        if (survivor) begin
          pend_vld_r <= 1'b1;
        end
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      in_r <= app_src;
    end
    if (issue) begin
      chk_idx_r <= scan_r[IDX_W-1:0];
    end
    if (survivor) begin
      pend_r <= rdata_r;
    end
    out_r <= out_nxt;
  end

  assign st.match     = hit;
  assign st.scan_done = !chk_vld_r && (scan_r >= count_r);
  assign st.mismatch  = (cfg.first_rows != cfg.second_rows) ||
                        (cfg.first_cols != cfg.second_cols);
  assign st.overflow  = ovf_r;
  assign st.count     = count_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/scaa_ctrl.sv @@
// command sequencer for clear, load, add search and finish scan
module scaa_ctrl import scaa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_cmd,
  input  dp_stat_t   st,
  output ctl_t       ctl,
  output logic       busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_t'(in_cmd))
            CMD_ADD:    state_nxt = S_SEARCH;
            CMD_FINISH: state_nxt = (st.mismatch || st.overflow) ? S_IDLE : S_EMIT;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (st.match || st.scan_done) state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (st.scan_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          unique case (cmd_t'(in_cmd))
            CMD_CLEAR: ctl.clear      = 1'b1;
            CMD_LOAD:  ctl.append     = 1'b1;
            CMD_ADD:   ctl.scan_start = 1'b1;
            CMD_FINISH: begin
              if (st.mismatch) begin
                ctl.emit_err = 1'b1;
                ctl.err_code = STAT_MISMATCH;
              end else if (st.overflow) begin
                ctl.emit_err = 1'b1;
                ctl.err_code = STAT_OVERFLOW;
              end else begin
                ctl.scan_start = 1'b1;
              end
            end
            default: ctl.clear = 1'b0;
          endcase
        end
      end
      S_SEARCH: begin
        if (st.match) begin
          ctl.update = 1'b1;
        end else begin
          ctl.scan = 1'b1;
          if (st.scan_done) ctl.append = 1'b1;
        end
      end
      S_EMIT: begin
        ctl.scan  = 1'b1;
        ctl.prune = 1'b1;
        if (st.scan_done) ctl.emit_final = 1'b1;
      end
      default: ctl.scan = 1'b0;
    endcase
  end

endmodule

@@ rtl/sparse_coo_add_accumulator.sv @@
// top level: register port, sequencer and entry-table datapath of the coo add accumulator
//
// channel  | ports                      | handshake
// ---------+----------------------------+--------------------------------------
// input    | start, busy, in_data       | word taken when start && !busy
// result   | out_valid, out_data        | one-cycle strobe, no back pressure
// config   | psel penable pwrite paddr  | apb write on psel && penable &&
//          | pwdata prdata pready       | pwrite, pready tied high
//
// clear and load leave busy low
// add reads one stored entry per cycle until a hit, and appends the word on a miss
// finish scans the whole table; errors answer at once
// the result register shows each word for one cycle, the last one with last set
// synchronous active-low reset clears the table count, overflow flag and valid flags and sets the config registers to 1
module sparse_coo_add_accumulator import scaa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  start,
  input  in_word_t              in_data,
  output logic                  busy,
  // result channel
  output logic                  out_valid,
  output out_word_t             out_data,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t     cfg_r;
  ctl_t     ctl;
  dp_stat_t dp_st;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  // registers sit at 4-byte steps
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_rows     <= 16'd1;
      cfg_r.first_cols     <= 16'd1;
      cfg_r.second_rows    <= 16'd1;
      cfg_r.second_cols    <= 16'd1;
      cfg_r.zero_threshold <= 31'd1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FIRST_ROWS:     cfg_r.first_rows     <= pwdata[15:0];
        REG_FIRST_COLS:     cfg_r.first_cols     <= pwdata[15:0];
        REG_SECOND_ROWS:    cfg_r.second_rows    <= pwdata[15:0];
        REG_SECOND_COLS:    cfg_r.second_cols    <= pwdata[15:0];
        REG_ZERO_THRESHOLD: cfg_r.zero_threshold <= pwdata[30:0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  // read-back of the register file, unused addresses read zero
  always_comb begin
    case (reg_idx)
      REG_FIRST_ROWS:     prdata = {16'd0, cfg_r.first_rows};
      REG_FIRST_COLS:     prdata = {16'd0, cfg_r.first_cols};
      REG_SECOND_ROWS:    prdata = {16'd0, cfg_r.second_rows};
      REG_SECOND_COLS:    prdata = {16'd0, cfg_r.second_cols};
      REG_ZERO_THRESHOLD: prdata = {1'b0, cfg_r.zero_threshold};
      default:            prdata = 32'd0;
    endcase
  end

  // sequencer: decodes the accepted word and steps the scans
  scaa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_data.cmd),
    .st     (dp_st),
    .ctl    (ctl),
    .busy   (busy)
  );

  // table memory, adder, pruning compare and result register
  scaa_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .st        (dp_st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // the table never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dp_st.count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // overflow is only ever flagged against a full table
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    dp_st.overflow |-> (dp_st.count == CNT_W'(CAPACITY)))
    else $error("overflow flagged with room left");

  // a clear empties the table and produces no word
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.cmd == CMD_CLEAR) |=> (!out_valid && dp_st.count == '0))
    else $error("clear left entries or emitted a word");

  // the last word of a finish coincides with the sequencer back in idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> !busy)
    else $error("last word while still busy");

  // status words are always final
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != STAT_ENTRY) |-> out_data.last)
    else $error("status word without last");

endmodule

@@ bench/sparse_coo_add_accumulator_tb.sv @@
// testbench of the sparse coordinate-list add accumulator: directed and random words, self-checking
module sparse_coo_add_accumulator_tb;
  import scaa_pkg::*;

  // cycles with no handshake of any kind before the run is declared hung;
  // slowest step is a full-table add scan or a 64-word finish plus a random input gap,
  // the pause before register writes is DRAIN_CYCLES
  localparam int QUIET_LIMIT  = 2000;
  // add scans at most CAPACITY entries, so this covers any word
  // still at work after the last result word has come out
  localparam int DRAIN_CYCLES = 80;
  localparam int ITEM_TARGET  = 235;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  start   = 1'b0;
  in_word_t              in_data = '0;
  logic                  busy;
  logic                  out_valid;
  out_word_t             out_data;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  sparse_coo_add_accumulator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow of the block: entry table, fill level, overflow flag and registers
  // ---------------------------------------------------------------------------
  logic [15:0]        shadow_row [CAPACITY];
  logic [15:0]        shadow_col [CAPACITY];
  logic signed [31:0] shadow_val [CAPACITY];
  int                 shadow_fill;
  logic               shadow_ovf;
  logic [15:0]        cfg_first_rows, cfg_first_cols, cfg_second_rows, cfg_second_cols;
  logic [30:0]        cfg_threshold;

  out_word_t due_words [$];      // result words still owed by the block
  in_word_t  waiting_words [$];  // words queued for the driver, not yet on the port

  int  queued_count = 0;  // words handed to the driver
  int  taken_count  = 0;  // words the block has accepted
  int  error_count  = 0;
  int  result_count = 0;
  int  entry_words = 0, empty_words = 0, mismatch_words = 0, overflow_words = 0;
  int  cfg_writes = 0;
  bit  in_taken = 1'b0;   // word accepted at the last rising edge
  bit  calm = 1'b0;       // no input gaps in the last part of the run
  int  gap_left = 0;

  // append to the shadow table, or flag the overflow when it is full
  function automatic void store_entry(logic [15:0] r, logic [15:0] c, logic signed [31:0] v);
    if (shadow_fill >= CAPACITY) begin
      shadow_ovf = 1'b1;
    end else begin
      shadow_row[shadow_fill] = r;
      shadow_col[shadow_fill] = c;
      shadow_val[shadow_fill] = v;
      shadow_fill++;
    end
  endfunction

  // update the shadow for one accepted word and queue the result words it owes
  function automatic void apply_word(in_word_t w);
    longint    sum, mag;
    bit        hit;
    out_word_t ow;
    out_word_t found [$];
    hit = 1'b0;
    ow  = '0;
    case (cmd_t'(w.cmd))
      CMD_CLEAR: begin
        shadow_fill = 0;
        shadow_ovf  = 1'b0;
      end
      CMD_LOAD: store_entry(w.row, w.col, w.value);
      CMD_ADD: begin
        // earliest matching coordinate takes the add, saturating
        for (int k = 0; k < shadow_fill && !hit; k++) begin
          if (shadow_row[k] == w.row && shadow_col[k] == w.col) begin
            sum = longint'(shadow_val[k]) + longint'(w.value);
            if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
            if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
            shadow_val[k] = sum[31:0];
            hit = 1'b1;
          end
        end
        if (!hit) store_entry(w.row, w.col, w.value);
      end
      CMD_FINISH: begin
        ow.last = 1'b1;
        if (cfg_first_rows != cfg_second_rows || cfg_first_cols != cfg_second_cols) begin
          ow.status = STAT_MISMATCH;
          due_words.push_back(ow);
        end else if (shadow_ovf) begin
          ow.status = STAT_OVERFLOW;
          due_words.push_back(ow);
        end else begin
          for (int k = 0; k < shadow_fill; k++) begin
            // exact magnitude: the most negative value counts as 2^31
            mag = longint'(shadow_val[k]);
            if (mag < 0) mag = -mag;
            if (mag >= longint'(cfg_threshold)) begin
              ow.out_row   = shadow_row[k];
              ow.out_col   = shadow_col[k];
              ow.out_value = shadow_val[k];
              ow.status    = STAT_ENTRY;
              ow.last      = 1'b0;
              found.push_back(ow);
            end
          end
          if (found.size() == 0) begin
            ow.status = STAT_EMPTY;
            due_words.push_back(ow);
          end else begin
            found[found.size()-1].last = 1'b1;
            foreach (found[i]) due_words.push_back(found[i]);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: inputs change on the falling edge, fed from waiting_words
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_words
    logic     nxt_start;
    in_word_t nxt_word;
    nxt_start = start;
    nxt_word  = in_data;
    if (rst_n && (!start || in_taken)) begin
      nxt_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (waiting_words.size() > 0) begin
        // random gap burst, this cycle being its first
        if (!calm && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 7) - 1;
        end else begin
          nxt_start = 1'b1;
          nxt_word  = waiting_words.pop_front();
        end
      end
    end
    start   <= nxt_start;
    in_data <= nxt_word;
  end

  // ---------------------------------------------------------------------------
  // monitor: samples at the rising edge, predicts, checks, watches for a hang
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    out_word_t  want;
    logic [31:0] reg_want;
    reg_idx_t   idx;
    bit         moved;
    static int  quiet_cycles = 0;
    if (!rst_n) begin
      in_taken        = 1'b0;
      shadow_fill     = 0;
      shadow_ovf      = 1'b0;
      cfg_first_rows  = 16'd1;
      cfg_first_cols  = 16'd1;
      cfg_second_rows = 16'd1;
      cfg_second_cols = 16'd1;
      cfg_threshold   = 31'd1;
    end else begin
      moved    = 1'b0;
      in_taken = start && !busy;
      if (in_taken) begin
        apply_word(in_data);
        taken_count++;
        moved = 1'b1;
      end

      // results cannot be held off: every strobe is taken here
      if (out_valid) begin
        moved = 1'b1;
        result_count++;
        if (due_words.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, out_data);
          error_count++;
        end else begin
          want = due_words.pop_front();
          case (stat_t'(want.status))
            STAT_ENTRY:    entry_words++;
            STAT_EMPTY:    empty_words++;
            STAT_MISMATCH: mismatch_words++;
            default:       overflow_words++;
          endcase
          if (out_data !== want) begin
            error_count++;
            if (out_data.out_row !== want.out_row)
              $display("%0t: out_row expected %h got %h", $time, want.out_row, out_data.out_row);
            if (out_data.out_col !== want.out_col)
              $display("%0t: out_col expected %h got %h", $time, want.out_col, out_data.out_col);
            if (out_data.out_value !== want.out_value)
              $display("%0t: out_value expected %h got %h", $time, want.out_value,
                       out_data.out_value);
            if (out_data.status !== want.status)
              $display("%0t: status expected %0d got %0d", $time, want.status, out_data.status);
            if (out_data.last !== want.last)
              $display("%0t: last expected %b got %b", $time, want.last, out_data.last);
          end
        end
      end

      // register port: writes update the shadow, reads are checked against it
      if (psel && penable && pready) begin
        moved = 1'b1;
        idx   = reg_idx_t'(paddr[4:2]);
        if (pwrite) begin
          cfg_writes++;
          case (idx)
            REG_FIRST_ROWS:     cfg_first_rows  = pwdata[15:0];
            REG_FIRST_COLS:     cfg_first_cols  = pwdata[15:0];
            REG_SECOND_ROWS:    cfg_second_rows = pwdata[15:0];
            REG_SECOND_COLS:    cfg_second_cols = pwdata[15:0];
            REG_ZERO_THRESHOLD: cfg_threshold   = pwdata[30:0];
            default: ;
          endcase
        end else begin
          case (idx)
            REG_FIRST_ROWS:     reg_want = {16'h0, cfg_first_rows};
            REG_FIRST_COLS:     reg_want = {16'h0, cfg_first_cols};
            REG_SECOND_ROWS:    reg_want = {16'h0, cfg_second_rows};
            REG_SECOND_COLS:    reg_want = {16'h0, cfg_second_cols};
            REG_ZERO_THRESHOLD: reg_want = {1'b0, cfg_threshold};
            default:            reg_want = '0;
          endcase
          if (prdata !== reg_want) begin
            $display("%0t: register %s read expected %h got %h", $time, idx.name(),
                     reg_want, prdata);
            error_count++;
          end
        end
      end

      // watchdog on cycles where nothing at all is handed over
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("sparse_coo_add_accumulator_tb failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_word(cmd_t c, logic [15:0] r, logic [15:0] cl, logic [31:0] v);
    in_word_t w;
    w.cmd   = c;
    w.row   = r;
    w.col   = cl;
    w.value = v;
    waiting_words.push_back(w);
    queued_count++;
  endtask

  // wait until every queued word is taken and answered, then let any
  // scan with no result owed run out before the registers are touched
  task automatic settle();
    while (taken_count != queued_count || due_words.size() != 0 || start)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one write then a read back of the same register
  task automatic set_reg(reg_idx_t idx, logic [31:0] data);
    for (int rd = 0; rd < 2; rd++) begin
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (rd == 0);
      paddr   <= CFG_ADDR_W'({idx, 2'b00});
      pwdata  <= data;
      @(negedge clk);
      penable <= 1'b1;
      @(negedge clk);
      while (!pready) @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic write_dims(logic [15:0] fr, logic [15:0] fc, logic [15:0] sr, logic [15:0] sc);
    set_reg(REG_FIRST_ROWS, {16'h0, fr});
    set_reg(REG_FIRST_COLS, {16'h0, fc});
    set_reg(REG_SECOND_ROWS, {16'h0, sr});
    set_reg(REG_SECOND_COLS, {16'h0, sc});
  endtask

  // values: extremes, zero, full random, mostly small Q16.16 around zero
  function automatic logic [31:0] pick_value();
    int s;
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom();
      default: begin
        s = int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
        return s;
      end
    endcase
  endfunction

  // coordinates mostly from a tiny pool so adds find their partners
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'hFFFF;
      1: return 16'($urandom());
      default: return 16'($urandom_range(0, 3));
    endcase
  endfunction

  // one clear / load / add / finish sequence, sometimes plain noise
  task automatic push_group();
    int loads, adds;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4))
        queue_word(cmd_t'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()), $urandom());
    end else begin
      // a full table now and then, by loads or by unmatched adds
      loads = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 8);
      adds  = $urandom_range(0, 8);
      queue_word(CMD_CLEAR, 16'($urandom()), 16'($urandom()), $urandom());
      repeat (loads) queue_word(CMD_LOAD, pick_coord(), pick_coord(), pick_value());
      repeat (adds) queue_word(CMD_ADD, pick_coord(), pick_coord(), pick_value());
      queue_word(CMD_FINISH, 16'($urandom()), 16'($urandom()), $urandom());
      if ($urandom_range(0, 3) == 0)
        queue_word(CMD_FINISH, 16'($urandom()), 16'($urandom()), $urandom());
    end
  endtask

  task automatic random_config();
    logic [15:0] r, c;
    logic [30:0] thr;
    r = 16'($urandom_range(1, 65535));
    c = 16'($urandom_range(1, 65535));
    case ($urandom_range(0, 9))
      0: write_dims(16'd1, 16'd1, 16'd1, 16'd1);
      1: write_dims(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      2: write_dims(r, c, (r == 16'hFFFF) ? 16'd1 : r + 16'd1, c);
      3: write_dims(r, c, r, (c == 16'hFFFF) ? 16'd1 : c + 16'd1);
      default: write_dims(r, c, r, c);
    endcase
    case ($urandom_range(0, 7))
      0: thr = 31'd0;
      1: thr = 31'd1;
      2: thr = 31'h7FFF_FFFF;
      3: thr = 31'($urandom());
      default: thr = 31'($urandom_range(0, 32'h3_0000));
    endcase
    set_reg(REG_ZERO_THRESHOLD, {1'b0, thr});
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset registers: 1x1 on both sides, threshold 1
    queue_word(CMD_FINISH, 16'h0, 16'h0, 32'h0);                  // empty table
    queue_word(CMD_LOAD,   16'h0000, 16'h0000, 32'h7FFF_FFFF);
    queue_word(CMD_LOAD,   16'hFFFF, 16'hFFFF, 32'h8000_0000);
    queue_word(CMD_LOAD,   16'h0000, 16'h0000, 32'h0000_0005);    // duplicate coordinate
    queue_word(CMD_ADD,    16'h0000, 16'h0000, 32'h0000_0001);    // saturates high
    queue_word(CMD_ADD,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);    // saturates low
    queue_word(CMD_ADD,    16'h1234, 16'hABCD, 32'h0);            // appended zero, pruned
    queue_word(CMD_LOAD,   16'h0001, 16'h0001, 32'hFFFF_FFFF);    // magnitude 1, kept
    queue_word(CMD_ADD,    16'h0000, 16'h0000, 32'hFFFF_FFFE);    // earliest duplicate hit
    queue_word(CMD_FINISH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_word(CMD_FINISH, 16'h0, 16'h0, 32'h0);                  // same words again
    queue_word(CMD_CLEAR,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_word(CMD_FINISH, 16'h0, 16'h0, 32'h0);
    settle();

    // largest threshold: only the two extreme values survive
    set_reg(REG_ZERO_THRESHOLD, 32'h7FFF_FFFF);
    queue_word(CMD_LOAD,   16'h0003, 16'h0003, 32'h8000_0000);
    queue_word(CMD_LOAD,   16'h0004, 16'h0004, 32'h7FFF_FFFF);
    queue_word(CMD_LOAD,   16'h0005, 16'h0005, 32'h7FFF_FFFE);
    queue_word(CMD_FINISH, 16'h0, 16'h0, 32'h0);
    settle();

    // zero threshold keeps every entry
    set_reg(REG_ZERO_THRESHOLD, 32'h0);
    queue_word(CMD_FINISH, 16'h0, 16'h0, 32'h0);
    settle();

    // row mismatch, then column mismatch
    write_dims(16'd1, 16'd1, 16'hFFFF, 16'd1);
    queue_word(CMD_FINISH, 16'h0, 16'h0, 32'h0);
    settle();
    write_dims(16'hFFFF, 16'd1, 16'hFFFF, 16'd2);
    queue_word(CMD_FINISH, 16'h0, 16'h0, 32'h0);
    settle();

    // random phases, each behind a fresh register setting
    while (queued_count < ITEM_TARGET) begin
      random_config();
      if (queued_count >= ITEM_TARGET - 60) calm = 1'b1;
      repeat ($urandom_range(1, 3)) push_group();
      settle();
    end

    $display("%0d words in, %0d result words out over %0d register writes",
             taken_count, result_count, cfg_writes);
    $display("entries %0d, empty %0d, mismatch %0d, overflow %0d, failures %0d",
             entry_words, empty_words, mismatch_words, overflow_words, error_count);
    if (error_count == 0 && due_words.size() == 0) begin
      $display("sparse_coo_add_accumulator_tb passed");
    end else begin
      $display("sparse_coo_add_accumulator_tb failed");
    end
    $finish;
  end

endmodule
